/* src/irtr_pkg.sv */
// Package: shared types and constants of the IR threshold serial receiver.
package irtr_pkg;

  localparam int ADC_W  = 10;
  localparam int THR_W  = 11;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 16;
  localparam int MULT_W = 6;

  localparam logic [THR_W-1:0] THRESH_MAX = 11'd2047;

  localparam logic [1:0] PH_CAL   = 2'd0;
  localparam logic [1:0] PH_IDLE  = 2'd1;
  localparam logic [1:0] PH_START = 2'd2;
  localparam logic [1:0] PH_DATA  = 2'd3;

  localparam logic [1:0] CFG_BIT_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_CAL_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_RANGE_MULT   = 2'd2;

  localparam logic [CFG_W-1:0]  BIT_PERIOD_RST   = 16'd160;
  localparam logic [CFG_W-1:0]  CAL_INTERVAL_RST = 16'd8;
  localparam logic [MULT_W-1:0] RANGE_MULT_RST   = 6'd21;

  typedef struct packed {
    logic              led_on;
    logic              calibrating;
    logic [THR_W-1:0]  level_threshold;
    logic              byte_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              start_glitch;
  } res_t;

endpackage

/* src/irtr_in_if.sv */
// Interface: sample channel into the receiver.
interface irtr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [irtr_pkg::ADC_W-1:0] adc_sample;

  modport source (output valid, operation, adc_sample, input ready);
  modport sink (input valid, operation, adc_sample, output ready);
endinterface

/* src/irtr_out_if.sv */
// Interface: result channel out of the receiver.
interface irtr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        led_on;
  logic                        calibrating;
  logic [irtr_pkg::THR_W-1:0]  level_threshold;
  logic                        byte_valid;
  logic [irtr_pkg::BYTE_W-1:0] data_byte;
  logic                        start_glitch;

  modport source (output valid, led_on, calibrating, level_threshold, byte_valid, data_byte,
                  start_glitch, input ready);
  modport sink (input valid, led_on, calibrating, level_threshold, byte_valid, data_byte,
                start_glitch, output ready);
endinterface

/* src/irtr_skid.sv */
// Two-entry result buffer between the receiver core and the result channel.
module irtr_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  irtr_pkg::res_t  push_data,
  output logic            room,
  output logic            pop_valid,
  input  logic            pop_ready,
  output irtr_pkg::res_t  pop_data
);
  import irtr_pkg::*;

  res_t head_r, head_nxt;
  res_t tail_r, tail_nxt;
  logic head_v_r, head_v_nxt;
  logic tail_v_r, tail_v_nxt;

  logic pop;
  logic head_v_aft;
  logic tail_v_aft;
  res_t head_aft;

  assign pop        = head_v_r && pop_ready;
  assign room       = !tail_v_r;
  assign pop_valid  = head_v_r;
  assign pop_data   = head_r;
  assign head_v_aft = pop ? tail_v_r : head_v_r;
  assign tail_v_aft = pop ? 1'b0 : tail_v_r;
  assign head_aft   = pop ? tail_r : head_r;

  always_comb begin
    head_v_nxt = head_v_aft;
    tail_v_nxt = tail_v_aft;
    head_nxt   = head_aft;
    tail_nxt   = tail_r;
    if (push) begin
      if (!head_v_aft) begin
        head_v_nxt = 1'b1;
        head_nxt   = push_data;
      end else begin
        tail_v_nxt = 1'b1;
        tail_nxt   = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    tail_v_r |-> head_v_r) else $error("tail entry held without head entry");

  a_stall_fills_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (push && head_v_r && !pop_ready) |=> tail_v_r) else $error("transfer lost on stall");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && !tail_v_r) |=> !head_v_r) else $error("result repeated after drain");

endmodule

/* src/ir_threshold_serial_receiver.sv */
// IR serial receiver with adaptive threshold: one sample transfer per clock cycle while the result buffer has room.
// The receiver takes one sample transfer in every cycle in which input ready is high; all
// work of a sample (calibration min/max, threshold multiply, start check, bit shift) is
// combinational and its result is registered into the result buffer. A two-entry result
// buffer lets input keep flowing while one result waits; input ready drops only when two
// results are held. After reset or a recalibrate request the receiver measures
// CAL_SAMPLES samples spaced cal_interval ticks apart, then sets its threshold and hunts
// for start bits; configuration writes take effect on the next sample.
module ir_threshold_serial_receiver #(
  parameter int CAL_SAMPLES = 32,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  irtr_in_if.sink                 in,
  irtr_out_if.source              out,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [irtr_pkg::CFG_W-1:0] cfg_wdata
);
  import irtr_pkg::*;

  localparam int CW = $clog2(CAL_SAMPLES + 1);
  localparam int TW = (SAMPLE_BITS + 1 > THR_W) ? SAMPLE_BITS + 1 : THR_W;
  localparam int PW = SAMPLE_BITS + MULT_W;

  logic [CFG_W-1:0]       bit_period_r;
  logic [CFG_W-1:0]       cal_interval_r;
  logic [MULT_W-1:0]      range_mult_r;

  logic [1:0]             phase_r,         phase_nxt;
  logic [CFG_W-1:0]       tick_count_r,    tick_count_nxt;
  logic [CW-1:0]          cal_taken_r,     cal_taken_nxt;
  logic [SAMPLE_BITS-1:0] range_min_r,     range_min_nxt;
  logic [SAMPLE_BITS-1:0] range_max_r,     range_max_nxt;
  logic [THR_W-1:0]       cal_threshold_r, cal_threshold_nxt;
  logic [3:0]             bits_taken_r,    bits_taken_nxt;
  logic [BYTE_W-1:0]      shift_byte_r,    shift_byte_nxt;

  logic                   accept;
  logic                   room;
  logic [SAMPLE_BITS-1:0] smp;
  logic [TW-1:0]          smp_ext;
  logic [TW-1:0]          thr_ext;
  logic [CFG_W:0]         tick_inc;
  logic [CFG_W-1:0]       iv;
  logic [CFG_W-1:0]       half;
  logic [CFG_W-1:0]       per;
  logic                   cal_tick;
  logic [SAMPLE_BITS-1:0] min_c;
  logic [SAMPLE_BITS-1:0] max_c;
  logic [CW-1:0]          taken_c;
  logic [SAMPLE_BITS-1:0] span;
  logic [PW-1:0]          prod;
  logic [TW-1:0]          thr_sum;
  logic [3:0]             bits_inc;
  logic [BYTE_W-1:0]      shifted;
  logic                   bit_val;
  res_t                   res;
  res_t                   res_out;

  assign accept   = in.valid && in.ready;
  assign in.ready = room;

  assign smp      = SAMPLE_BITS'(in.adc_sample);
  assign smp_ext  = TW'(smp);
  assign thr_ext  = TW'(cal_threshold_r);
  assign tick_inc = {1'b0, tick_count_r} + {{CFG_W{1'b0}}, 1'b1};
  assign iv       = (cal_interval_r == '0) ? CFG_W'(1) : cal_interval_r;
  assign half     = (bit_period_r[CFG_W-1:1] == '0) ? CFG_W'(1) : {1'b0, bit_period_r[CFG_W-1:1]};
  assign per      = (bit_period_r == '0) ? CFG_W'(1) : bit_period_r;

  assign cal_tick = (tick_count_r == '0);
  assign min_c    = (cal_tick && smp < range_min_r) ? smp : range_min_r;
  assign max_c    = (cal_tick && smp > range_max_r) ? smp : range_max_r;
  assign taken_c  = cal_taken_r + CW'(cal_tick);
  assign span     = (max_c >= min_c) ? max_c - min_c : '0;
  assign prod     = PW'(span) * PW'(range_mult_r);
  assign thr_sum  = TW'(max_c) + TW'(prod[PW-1:MULT_W]);

  assign bits_inc = bits_taken_r + 4'd1;
  assign bit_val  = smp_ext > thr_ext;
  assign shifted  = {bit_val, shift_byte_r[BYTE_W-1:1]};

  always_comb begin
    phase_nxt         = phase_r;
    tick_count_nxt    = tick_count_r;
    cal_taken_nxt     = cal_taken_r;
    range_min_nxt     = range_min_r;
    range_max_nxt     = range_max_r;
    cal_threshold_nxt = cal_threshold_r;
    bits_taken_nxt    = bits_taken_r;
    shift_byte_nxt    = shift_byte_r;
    res               = '0;
    if (in.operation) begin
      phase_nxt      = PH_CAL;
      tick_count_nxt = '0;
      cal_taken_nxt  = '0;
      range_min_nxt  = '1;
      range_max_nxt  = '0;
      bits_taken_nxt = '0;
      shift_byte_nxt = '0;
    end else begin
      unique case (phase_r)
        PH_CAL: begin
          range_min_nxt  = min_c;
          range_max_nxt  = max_c;
          cal_taken_nxt  = taken_c;
          tick_count_nxt = (tick_inc >= {1'b0, iv}) ? '0 : tick_inc[CFG_W-1:0];
          if (taken_c >= CW'(CAL_SAMPLES)) begin
            if (thr_sum > TW'(THRESH_MAX)) begin
              cal_threshold_nxt = THRESH_MAX;
            end else begin
              cal_threshold_nxt = thr_sum[THR_W-1:0];
            end
            phase_nxt      = PH_IDLE;
            tick_count_nxt = '0;
            cal_taken_nxt  = '0;
          end
        end
        PH_IDLE: begin
          if (smp_ext >= thr_ext) begin
            phase_nxt      = PH_START;
            tick_count_nxt = '0;
          end
        end
        PH_START: begin
          tick_count_nxt = tick_inc[CFG_W-1:0];
          if (tick_inc >= {1'b0, half}) begin
            tick_count_nxt = '0;
            if (bit_val) begin
              phase_nxt      = PH_DATA;
              bits_taken_nxt = '0;
              shift_byte_nxt = '0;
            end else begin
              phase_nxt        = PH_IDLE;
              res.start_glitch = 1'b1;
            end
          end
        end
        default: begin
          tick_count_nxt = tick_inc[CFG_W-1:0];
          if (tick_inc >= {1'b0, per}) begin
            tick_count_nxt = '0;
            shift_byte_nxt = shifted;
            bits_taken_nxt = bits_inc;
            if (bits_inc >= 4'd8) begin
              res.byte_valid = 1'b1;
              res.data_byte  = shifted;
              bits_taken_nxt = '0;
              shift_byte_nxt = '0;
              phase_nxt      = PH_IDLE;
            end
          end
        end
      endcase
    end
    res.led_on          = (phase_nxt == PH_CAL);
    res.calibrating     = (phase_nxt == PH_CAL);
    res.level_threshold = cal_threshold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_CAL;
      tick_count_r    <= '0;
      cal_taken_r     <= '0;
      range_min_r     <= '1;
      range_max_r     <= '0;
      cal_threshold_r <= '0;
      bits_taken_r    <= '0;
      shift_byte_r    <= '0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      tick_count_r    <= tick_count_nxt;
      cal_taken_r     <= cal_taken_nxt;
      range_min_r     <= range_min_nxt;
      range_max_r     <= range_max_nxt;
      cal_threshold_r <= cal_threshold_nxt;
      bits_taken_r    <= bits_taken_nxt;
      shift_byte_r    <= shift_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r   <= BIT_PERIOD_RST;
      cal_interval_r <= CAL_INTERVAL_RST;
      range_mult_r   <= RANGE_MULT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIT_PERIOD:   bit_period_r   <= cfg_wdata;
        CFG_CAL_INTERVAL: cal_interval_r <= cfg_wdata;
        CFG_RANGE_MULT:   range_mult_r   <= cfg_wdata[MULT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  irtr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .room      (room),
    .pop_valid (out.valid),
    .pop_ready (out.ready),
    .pop_data  (res_out)
  );

  assign out.led_on          = res_out.led_on;
  assign out.calibrating     = res_out.calibrating;
  assign out.level_threshold = res_out.level_threshold;
  assign out.byte_valid      = res_out.byte_valid;
  assign out.data_byte       = res_out.data_byte;
  assign out.start_glitch    = res_out.start_glitch;

  a_byte_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.byte_valid) |=> (phase_r == PH_IDLE)) else $error("byte done outside idle return");

  a_cal_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_CAL) |-> (cal_taken_r == '0)) else $error("calibration count left set");

  a_bits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (bits_taken_r < 4'd8)) else $error("data bit count overrun");

endmodule
